// File: design/fls_pkg.sv
// shared types, constants and the crc-16 byte step for the frame and line splitter
// no dependencies; used by the top level, the controller, the datapath and the bench
package fls_pkg;

  // character codes that end a text line
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  // crc-16, reflected polynomial
  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  // configuration register indexes and reset values
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [7:0] HEADER_FIRST_RST  = 8'hAA;
  localparam logic [7:0] HEADER_SECOND_RST = 8'h55;

  // default line capacity
  localparam int unsigned LINE_CHARS_DEF = 63;

  // result kinds
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  // frame byte positions (frame count values)
  localparam int unsigned FCNT_W = 3;
  localparam logic [FCNT_W-1:0] FPOS_IDLE   = 3'd0;
  localparam logic [FCNT_W-1:0] FPOS_HDR1   = 3'd1;
  localparam logic [FCNT_W-1:0] FPOS_CMD    = 3'd2;
  localparam logic [FCNT_W-1:0] FPOS_CRC_HI = 3'd3;
  localparam logic [FCNT_W-1:0] FPOS_CRC_LO = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic accept;     // input item taken this cycle
    logic rd_en;      // read line store at the readout index
    logic load_char;  // move read data into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;    // output register empty or being drained
    logic start_line;  // current input byte ends a non-empty line
    logic last_char;   // readout index is at the final stored character
  } ctrl_sts_t;

  // one byte through the crc register, lsb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: design/fls_if.sv
// handshake channel interfaces for the frame and line splitter
// no dependencies
interface fls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fls_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload;
  logic       last;
  modport source (output valid, output kind, output payload, output last, input ready);
  modport sink   (input valid, input kind, input payload, input last, output ready);
endinterface

interface fls_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/binary_frame_and_text_line_splitter.sv
// top level of the binary frame and text line splitter
// depends on fls_pkg, fls_if, fls_ctrl, fls_datapath (and fls_ram below it)
//
//   channel  dir  signals                              moves
//   in_ch    in   valid ready rx_byte                  one received byte per item
//   out_ch   out  valid ready kind payload last        one text char or command per item
//   cfg_ch   in   valid ready index data               one header register write
//
// a byte that produces no readout is taken when the controller is idle and the output register is free
// a line end with n stored chars is taken, then holds off input while the chars are read out:
//   each char goes through a line store read state, then a load state that waits for a free output register
// input also waits while any result sits untaken in the output register
// rst_n is synchronous, active low; header registers reset to 0xaa and 0x55
// cfg_ch is always ready; line store contents are not cleared by reset
module binary_frame_and_text_line_splitter #(
  parameter int unsigned LINE_CHARS = fls_pkg::LINE_CHARS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fls_in_if.sink    in_ch,
  fls_out_if.source out_ch,
  fls_cfg_if.sink   cfg_ch
);

  // command and status between controller and datapath
  fls_pkg::ctrl_cmd_t cmd;
  fls_pkg::ctrl_sts_t sts;

  // controller: decides when a byte is taken and steps the line readout
  fls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: header match, running crc, line store and the output register
  fls_datapath #(
    .LINE_CHARS (LINE_CHARS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_rx_byte  (in_ch.rx_byte),
    .cfg_valid   (cfg_ch.valid),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .cfg_ready   (cfg_ch.ready),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_kind    (out_ch.kind),
    .out_payload (out_ch.payload),
    .out_last    (out_ch.last),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

// File: design/fls_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module fls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/fls_ctrl.sv
// controller state machine: input acceptance and line readout sequencing
// depends on fls_pkg
module fls_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fls_pkg::ctrl_sts_t sts,
  output fls_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_LOAD
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    in_ready      = (state_r == ST_IDLE) && sts.out_free;
    cmd.accept    = in_valid && in_ready;
    cmd.rd_en     = (state_r == ST_RD);
    cmd.load_char = (state_r == ST_LOAD) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept && sts.start_line) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (cmd.load_char) begin
          state_nxt = sts.last_char ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/fls_datapath.sv
// datapath: header registers, frame tracking with running crc, line store and
// output register; depends on fls_pkg and fls_ram
module fls_datapath #(
  parameter int unsigned LINE_CHARS = fls_pkg::LINE_CHARS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [7:0]                     in_rx_byte,
  input  logic                           cfg_valid,
  input  logic [fls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data,
  output logic                           cfg_ready,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           out_kind,
  output logic [7:0]                     out_payload,
  output logic                           out_last,
  input  fls_pkg::ctrl_cmd_t             cmd,
  output fls_pkg::ctrl_sts_t             sts
);

  localparam int unsigned AW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
  localparam int unsigned CW = $clog2(LINE_CHARS + 1);
  localparam logic [CW-1:0] LINE_MAX = CW'(LINE_CHARS);

  // configuration
  logic [7:0] hdr_first_r;
  logic [7:0] hdr_second_r;

  // frame tracking
  logic                       hdr_seen_r;
  logic [fls_pkg::FCNT_W-1:0] fcnt_r;
  logic [15:0]                crc_r;
  logic [7:0]                 cmd_byte_r;
  logic [7:0]                 crc_hi_r;

  // line tracking
  logic [CW-1:0] line_cnt_r;
  logic [AW-1:0] rd_idx_r;
  logic [7:0]    ram_rdata;

  // output register
  logic       out_valid_r;
  logic       out_kind_r;
  logic [7:0] out_payload_r;
  logic       out_last_r;

  logic        is_start;
  logic        is_confirm;
  logic        is_text;
  logic        is_term;
  logic        crc_ok;
  logic        emit_cmd;
  logic        line_we;
  logic [15:0] crc_upd;

  assign cfg_ready = 1'b1;

  always_comb begin
    is_start   = !hdr_seen_r && (fcnt_r == fls_pkg::FPOS_IDLE) && (in_rx_byte == hdr_first_r);
    is_confirm = !hdr_seen_r && (fcnt_r == fls_pkg::FPOS_HDR1) && (in_rx_byte == hdr_second_r);
    is_text    = !hdr_seen_r && !is_start && !is_confirm;
    is_term    = (in_rx_byte == fls_pkg::CHAR_LF) || (in_rx_byte == fls_pkg::CHAR_CR);
    crc_upd    = fls_pkg::crc16_byte(is_start ? fls_pkg::CRC_INIT : crc_r, in_rx_byte);
    crc_ok     = ({crc_hi_r, in_rx_byte} == ~crc_r);
    emit_cmd   = hdr_seen_r && (fcnt_r == fls_pkg::FPOS_CRC_LO) && crc_ok;
    line_we    = cmd.accept && is_text && !is_term && (line_cnt_r < LINE_MAX);

    sts.out_free   = !out_valid_r || out_ready;
    sts.start_line = is_text && is_term && (line_cnt_r != '0);
    sts.last_char  = (CW'(rd_idx_r) == (line_cnt_r - CW'(1)));
  end

  // header registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_first_r  <= fls_pkg::HEADER_FIRST_RST;
      hdr_second_r <= fls_pkg::HEADER_SECOND_RST;
    end else if (cfg_valid) begin
      if (cfg_index == fls_pkg::REG_HEADER_FIRST) begin
        hdr_first_r <= cfg_data;
      end
      if (cfg_index == fls_pkg::REG_HEADER_SECOND) begin
        hdr_second_r <= cfg_data;
      end
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_seen_r <= 1'b0;
      fcnt_r     <= fls_pkg::FPOS_IDLE;
    end else if (cmd.accept) begin
      if (is_start) begin
        fcnt_r <= fls_pkg::FPOS_HDR1;
      end else if (is_confirm) begin
        fcnt_r     <= fls_pkg::FPOS_CMD;
        hdr_seen_r <= 1'b1;
      end else if (hdr_seen_r) begin
        case (fcnt_r)
          fls_pkg::FPOS_CMD:    fcnt_r <= fls_pkg::FPOS_CRC_HI;
          fls_pkg::FPOS_CRC_HI: fcnt_r <= fls_pkg::FPOS_CRC_LO;
          default: begin
            fcnt_r     <= fls_pkg::FPOS_IDLE;
            hdr_seen_r <= 1'b0;
          end
        endcase
      end
    end
  end

  // frame payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (is_start || is_confirm || (hdr_seen_r && fcnt_r == fls_pkg::FPOS_CMD)) begin
        crc_r <= crc_upd;
      end
      if (hdr_seen_r && fcnt_r == fls_pkg::FPOS_CMD) begin
        cmd_byte_r <= in_rx_byte;
      end
      if (hdr_seen_r && fcnt_r == fls_pkg::FPOS_CRC_HI) begin
        crc_hi_r <= in_rx_byte;
      end
    end
  end

  // line count and readout index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cnt_r <= '0;
      rd_idx_r   <= '0;
    end else begin
      if (line_we) begin
        line_cnt_r <= line_cnt_r + CW'(1);
      end else if (cmd.load_char && sts.last_char) begin
        line_cnt_r <= '0;
      end
      if (cmd.accept) begin
        rd_idx_r <= '0;
      end else if (cmd.load_char) begin
        rd_idx_r <= rd_idx_r + AW'(1);
      end
    end
  end

  fls_ram #(
    .WIDTH (8),
    .DEPTH (LINE_CHARS)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_cnt_r[AW-1:0]),
    .wdata (in_rx_byte),
    .re    (cmd.rd_en),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_char || (cmd.accept && emit_cmd)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      out_kind_r    <= fls_pkg::KIND_TEXT;
      out_payload_r <= ram_rdata;
      out_last_r    <= sts.last_char;
    end else if (cmd.accept && emit_cmd) begin
      out_kind_r    <= fls_pkg::KIND_CMD;
      out_payload_r <= cmd_byte_r;
      out_last_r    <= 1'b1;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_payload = out_payload_r;
  assign out_last    = out_last_r;

`ifndef SYNTHESIS
  a_line_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    line_cnt_r <= LINE_MAX)
    else $error("line count beyond capacity");

  a_hdr_seen_pos: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_seen_r |-> (fcnt_r == fls_pkg::FPOS_CMD || fcnt_r == fls_pkg::FPOS_CRC_HI ||
                    fcnt_r == fls_pkg::FPOS_CRC_LO))
    else $error("header seen with frame position out of range");

  a_cmd_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == fls_pkg::KIND_CMD) |-> out_last_r)
    else $error("command result without last mark");

  a_line_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_char && sts.last_char) |=> (line_cnt_r == '0))
    else $error("line count not cleared after final character");

  a_no_accept_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en || cmd.load_char) |-> !cmd.accept)
    else $error("input accepted during line readout");
`endif

endmodule

// File: verif/tb_binary_frame_and_text_line_splitter.sv
// self-checking bench for the binary frame and text line splitter
// drives bytes, header register writes and result backpressure through the fls_if channels
// depends on fls_pkg, fls_if and the binary_frame_and_text_line_splitter design
module tb_binary_frame_and_text_line_splitter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_CAP    = fls_pkg::LINE_CHARS_DEF;
  localparam int FRAME_BYTES = 5;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_BYTES = 56;

  // one result item as it leaves the block
  typedef struct packed {
    logic       kind;
    logic [7:0] payload;
    logic       last;
  } pkt_t;

  // one row of the directed table; given < 0 means the predictor decides
  typedef struct {
    logic [7:0] b;
    int         given;
    pkt_t       want;
  } row_t;

  localparam pkt_t NO_PKT = '0;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  fls_in_if  in_ch ();
  fls_out_if out_ch ();
  fls_cfg_if cfg_ch ();

  binary_frame_and_text_line_splitter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the header registers
  logic [7:0] hdr_a = fls_pkg::HEADER_FIRST_RST;
  logic [7:0] hdr_b = fls_pkg::HEADER_SECOND_RST;

  // predictor copy of the parser state
  logic [fls_pkg::FCNT_W-1:0] pos_cnt = fls_pkg::FPOS_IDLE;
  logic                       sync_ok = 1'b0;
  logic [7:0]                 frm_buf [FRAME_BYTES];
  logic [5:0]                 txt_len = '0;
  logic [7:0]                 txt_buf [LINE_CAP];

  // results caused by the latest byte, and every result still owed by the block
  pkt_t step_out [$];
  pkt_t want_q [$];

  // run statistics
  int   mism      = 0;
  int   bytes_in  = 0;
  int   cmd_seen  = 0;
  int   char_seen = 0;
  int   line_seen = 0;
  int   reg_wr    = 0;
  int   cycle_cnt = 0;
  bit   no_idle   = 1'b0;

  // crc-16 over the three leading frame bytes: reflected 0x8408, zero start, inverted out
  function automatic logic [15:0] frame_crc(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2);
    logic [15:0] r;
    logic [7:0]  d [3];
    int          i;
    int          j;
    d[0] = b0;
    d[1] = b1;
    d[2] = b2;
    r = 16'h0000;
    for (i = 0; i < 3; i++) begin
      r = r ^ {8'h00, d[i]};
      for (j = 0; j < 8; j++) begin
        r = r[0] ? ((r >> 1) ^ fls_pkg::CRC_POLY) : (r >> 1);
      end
    end
    return ~r;
  endfunction

  // advance the predicted parser by one byte and collect the results it causes
  function automatic void split_byte(input logic [7:0] b);
    int k;
    step_out.delete();
    // first sync byte only counts when idle and no header is open
    if (!sync_ok && pos_cnt == fls_pkg::FPOS_IDLE && b == hdr_a) begin
      frm_buf[0] = b;
      pos_cnt = fls_pkg::FPOS_HDR1;
      return;
    end
    // second sync byte confirms the header; until then text keeps flowing
    if (!sync_ok && pos_cnt == fls_pkg::FPOS_HDR1 && b == hdr_b) begin
      frm_buf[1] = b;
      pos_cnt = fls_pkg::FPOS_CMD;
      sync_ok = 1'b1;
      return;
    end
    // inside a frame: command then crc high and low
    if (sync_ok) begin
      if (pos_cnt < FRAME_BYTES) begin
        frm_buf[pos_cnt] = b;
        pos_cnt = pos_cnt + 1'b1;
      end
      if (pos_cnt >= FRAME_BYTES) begin
        if ({frm_buf[3], frm_buf[4]} == frame_crc(frm_buf[0], frm_buf[1], frm_buf[2])) begin
          step_out.push_back('{fls_pkg::KIND_CMD, frm_buf[2], 1'b1});
        end
        sync_ok = 1'b0;
        pos_cnt = fls_pkg::FPOS_IDLE;
      end
      return;
    end
    // text path: cr or lf flushes a non-empty line, overflow chars are dropped
    if (b == fls_pkg::CHAR_LF || b == fls_pkg::CHAR_CR) begin
      for (k = 0; k < txt_len; k++) begin
        step_out.push_back('{fls_pkg::KIND_TEXT, txt_buf[k], k == int'(txt_len) - 1});
      end
      txt_len = '0;
    end else if (txt_len < LINE_CAP) begin
      txt_buf[txt_len] = b;
      txt_len = txt_len + 1'b1;
    end
  endfunction

  // idle draw shared by both sides, zero during calm stretches
  function automatic int pick_wait();
    return no_idle ? 0 : $urandom_range(0, 6);
  endfunction

  // random text char that never ends the line
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == fls_pkg::CHAR_LF || c == fls_pkg::CHAR_CR) begin
      c = c ^ 8'h40;
    end
    return c;
  endfunction

  // present one byte and return at the edge where it is taken; valid stays high
  task automatic feed_byte(input logic [7:0] b);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_in++;
  endtask

  // send a byte and queue whatever the predictor says it produces
  task automatic send_byte(input logic [7:0] b);
    feed_byte(b);
    split_byte(b);
    foreach (step_out[i]) want_q.push_back(step_out[i]);
  endtask

  // sender backs off until every owed result has come, plus a short settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // header register write; cfg valid is left high for a following write
  task automatic put_reg(input logic [fls_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      fls_pkg::REG_HEADER_FIRST:  hdr_a = val;
      fls_pkg::REG_HEADER_SECOND: hdr_b = val;
      default: ;
    endcase
    reg_wr++;
  endtask

  // one random sequence: mostly well-formed frames and lines, some broken ones and noise
  task automatic run_sequence(input int sel);
    logic [7:0]  fb [FRAME_BYTES];
    logic [15:0] crc;
    int          n;
    int          i;
    int          j;
    if (sel < 35 || (sel >= 70 && sel < 78)) begin
      // frame, corrupted in one bit for the broken share
      fb[0] = hdr_a;
      fb[1] = hdr_b;
      fb[2] = 8'($urandom_range(0, 255));
      crc = frame_crc(fb[0], fb[1], fb[2]);
      fb[3] = crc[15:8];
      fb[4] = crc[7:0];
      if (sel >= 70) begin
        j = $urandom_range(2, 4);
        n = $urandom_range(0, 7);
        fb[j][n] = ~fb[j][n];
      end
      for (i = 0; i < FRAME_BYTES; i++) send_byte(fb[i]);
    end else if (sel < 70) begin
      // short line, zero length gives an empty line
      n = $urandom_range(0, 12);
      for (i = 0; i < n; i++) send_byte(text_char());
      send_byte($urandom_range(0, 1) ? fls_pkg::CHAR_LF : fls_pkg::CHAR_CR);
    end else if (sel < 90) begin
      // raw noise over the full byte range
      n = $urandom_range(1, 5);
      for (i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
    end else if (sel < 95) begin
      // lone first header, text in between, then the rest of the frame
      send_byte(hdr_a);
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
        send_byte(($urandom_range(0, 2) == 0) ? hdr_a : text_char());
      end
      if ($urandom_range(0, 1)) send_byte(fls_pkg::CHAR_LF);
      fb[2] = 8'($urandom_range(0, 255));
      crc = frame_crc(hdr_a, hdr_b, fb[2]);
      send_byte(hdr_b);
      send_byte(fb[2]);
      send_byte(crc[15:8]);
      send_byte(crc[7:0]);
    end else begin
      // long line that can run past capacity
      n = $urandom_range(55, 75);
      for (i = 0; i < n; i++) send_byte(text_char());
      send_byte($urandom_range(0, 1) ? fls_pkg::CHAR_CR : fls_pkg::CHAR_LF);
    end
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, want_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stalls, every item checked against the oldest expectation
  initial begin : result_sink
    pkt_t seen;
    pkt_t due;
    int   stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = pick_wait();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      seen = '{out_ch.kind, out_ch.payload, out_ch.last};
      if (seen.kind == fls_pkg::KIND_CMD) begin
        cmd_seen++;
      end else begin
        char_seen++;
        if (seen.last) line_seen++;
      end
      if (want_q.size() == 0) begin
        mism++;
        if (mism <= 10) begin
          $display("unexpected result: kind %0d payload %02h last %0d",
                   seen.kind, seen.payload, seen.last);
        end
      end else begin
        due = want_q.pop_front();
        if (seen.kind !== due.kind || seen.payload !== due.payload ||
            seen.last !== due.last) begin
          mism++;
          if (mism <= 10) begin
            $display("result mismatch: expected kind %0d payload %02h last %0d",
                     due.kind, due.payload, due.last);
            $display("                 got kind %0d payload %02h last %0d",
                     seen.kind, seen.payload, seen.last);
          end
        end
      end
    end
  end

  // stimulus: directed table at reset headers, then random phases over several header pairs
  initial begin : stimulus
    row_t        steps [$];
    logic [15:0] c;
    logic [7:0]  hf_set [5];
    logic [7:0]  hs_set [5];
    int          ph;
    int          start_cnt;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= fls_pkg::REG_HEADER_FIRST;
    cfg_ch.data   <= 8'h00;

    // single char line, then an empty line
    steps.push_back('{8'h41, 0, NO_PKT});
    steps.push_back('{fls_pkg::CHAR_LF, 1, '{fls_pkg::KIND_TEXT, 8'h41, 1'b1}});
    steps.push_back('{fls_pkg::CHAR_CR, 0, NO_PKT});
    // good frame with command 0x00
    c = frame_crc(fls_pkg::HEADER_FIRST_RST, fls_pkg::HEADER_SECOND_RST, 8'h00);
    steps.push_back('{fls_pkg::HEADER_FIRST_RST, 0, NO_PKT});
    steps.push_back('{fls_pkg::HEADER_SECOND_RST, 0, NO_PKT});
    steps.push_back('{8'h00, 0, NO_PKT});
    steps.push_back('{c[15:8], 0, NO_PKT});
    steps.push_back('{c[7:0], -1, NO_PKT});
    // frame with command 0xff and a crc one bit off: dropped
    c = frame_crc(fls_pkg::HEADER_FIRST_RST, fls_pkg::HEADER_SECOND_RST, 8'hFF) ^ 16'h0001;
    steps.push_back('{fls_pkg::HEADER_FIRST_RST, 0, NO_PKT});
    steps.push_back('{fls_pkg::HEADER_SECOND_RST, 0, NO_PKT});
    steps.push_back('{8'hFF, 0, NO_PKT});
    steps.push_back('{c[15:8], 0, NO_PKT});
    steps.push_back('{c[7:0], 0, NO_PKT});
    // lone first header: text and a repeated first header go to the line, then the frame ends
    c = frame_crc(fls_pkg::HEADER_FIRST_RST, fls_pkg::HEADER_SECOND_RST, 8'h5A);
    steps.push_back('{fls_pkg::HEADER_FIRST_RST, 0, NO_PKT});
    steps.push_back('{8'h78, -1, NO_PKT});
    steps.push_back('{fls_pkg::HEADER_FIRST_RST, -1, NO_PKT});
    steps.push_back('{fls_pkg::CHAR_LF, -1, NO_PKT});
    steps.push_back('{fls_pkg::HEADER_SECOND_RST, -1, NO_PKT});
    steps.push_back('{8'h5A, -1, NO_PKT});
    steps.push_back('{c[15:8], -1, NO_PKT});
    steps.push_back('{c[7:0], -1, NO_PKT});
    // zero and all-ones chars in a line
    steps.push_back('{8'h00, -1, NO_PKT});
    steps.push_back('{8'hFF, -1, NO_PKT});
    steps.push_back('{fls_pkg::CHAR_CR, -1, NO_PKT});

    // header pairs per phase: extremes, line-end codes as headers, equal headers, random
    hf_set = '{8'h00, 8'hFF, fls_pkg::CHAR_CR, 8'h7E, 8'($urandom_range(0, 255))};
    hs_set = '{8'hFF, 8'h00, fls_pkg::CHAR_LF, 8'h7E, 8'($urandom_range(0, 255))};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: typed rows queue their given result, others follow the predictor
    foreach (steps[i]) begin
      feed_byte(steps[i].b);
      split_byte(steps[i].b);
      if (steps[i].given < 0) begin
        foreach (step_out[k]) want_q.push_back(step_out[k]);
      end else if (steps[i].given > 0) begin
        want_q.push_back(steps[i].want);
      end
    end

    // random phases, headers rewritten only once the block has gone quiet
    for (ph = 0; ph < 5; ph++) begin
      drain_results();
      put_reg(fls_pkg::REG_HEADER_FIRST, hf_set[ph]);
      put_reg(fls_pkg::REG_HEADER_SECOND, hs_set[ph]);
      cfg_ch.valid <= 1'b0;
      start_cnt = bytes_in;
      // first phase opens with a long line that can overflow
      if (ph == 0) run_sequence(99);
      while (bytes_in - start_cnt < PHASE_BYTES) begin
        if ($urandom_range(0, 7) == 0) no_idle = !no_idle;
        if ($urandom_range(0, 29) == 0) drain_results();
        run_sequence($urandom_range(0, 99));
      end
    end

    // let the last results out, then a short settle
    in_ch.valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d bytes over %0d header writes in %0d cycles", bytes_in, reg_wr, cycle_cnt);
    $display("checked %0d commands and %0d line chars in %0d lines, %0d mismatches",
             cmd_seen, char_seen, line_seen, mism);
    if (mism == 0 && want_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
